/* design/dst_transition_date_core_defines.svh */
// Assertion helpers shared by the transition date core
`ifndef DST_TRANSITION_DATE_CORE_DEFINES_SVH
`define DST_TRANSITION_DATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define DSTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define DSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dstd_pkg.sv */
`default_nettype none

package dstd_pkg;

    localparam int TDATA_W = 56;

    // Fixed-point reciprocal of 100: floor(x / 100) = (x * 5243) >> 19 for x < 43699
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [3:0] OCC_LAST = 4'd5;
    localparam logic [2:0] WD_SPAN  = 3'd7;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [2:0] MONTH_SHIFT [12] = '{
        3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
        3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
    };
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [3:0] MONTH_FEB    = 4'd2;
    localparam logic [3:0] MONTH_MAR    = 4'd3;
    localparam logic [3:0] MONTH_DEC    = 4'd12;

    // Input beat, last field (year) in the low bits
    typedef struct packed {
        logic [9:0]  rule_millis;
        logic [5:0]  rule_second;
        logic [5:0]  rule_minute;
        logic [4:0]  rule_hour;
        logic [2:0]  rule_weekday;
        logic [2:0]  rule_occurrence;
        logic [3:0]  rule_month;
        logic [14:0] year;
    } in_beat_t;

    // Result beat, last field (out_year) in the low bits
    typedef struct packed {
        logic [9:0]  out_millis;
        logic [5:0]  out_second;
        logic [5:0]  out_minute;
        logic [4:0]  out_hour;
        logic [2:0]  out_weekday;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [14:0] out_year;
    } result_t;

    localparam int IN_PAD_W  = TDATA_W - $bits(in_beat_t);
    localparam int OUT_PAD_W = TDATA_W - $bits(result_t);

    // Normalized rule that rides along the pipe
    typedef struct packed {
        logic [14:0] year;
        logic [3:0]  month;
        logic        month_ok;
        logic        last;
        logic [1:0]  nth;
        logic [2:0]  wd;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } rule_t;

    typedef struct packed {
        rule_t       rule;
        logic [15:0] a;
        logic [8:0]  qa;
        logic [8:0]  qy;
    } s1_t;

    typedef struct packed {
        rule_t       rule;
        logic [4:0]  dim;
        logic [15:0] ref_sum;
    } s2_t;

    typedef struct packed {
        rule_t      rule;
        logic [4:0] dim;
        logic [2:0] off;
    } s3_t;

    // Month length, zero for months outside 1..12
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        logic [4:0] len;
        idx = month - 4'd1;
        len = 5'd0;
        if (month != 4'd0 && month <= MONTH_DEC) begin
            len = MONTH_LEN[idx];
            if (month == MONTH_FEB && leap) begin
                len = FEB_LEAP_LEN;
            end
        end
        return len;
    endfunction

    // Month offset for the weekday sum, zero for months outside 1..12
    function automatic logic [2:0] month_shift(input logic [3:0] month);
        logic [3:0] idx;
        logic [2:0] sh;
        idx = month - 4'd1;
        sh  = 3'd0;
        if (month != 4'd0 && month <= MONTH_DEC) begin
            sh = MONTH_SHIFT[idx];
        end
        return sh;
    endfunction

    // x mod 7 by folding octal digits (8 == 1 mod 7)
    function automatic logic [2:0] mod7_16(input logic [15:0] v);
        logic [5:0] f1;
        logic [3:0] f2;
        f1 = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]} + {3'b0, v[11:9]}
           + {3'b0, v[14:12]} + {5'b0, v[15]};
        f2 = {1'b0, f1[2:0]} + {1'b0, f1[5:3]};
        if (f2 >= 4'(WD_SPAN)) begin
            f2 = f2 - 4'(WD_SPAN);
        end
        return f2[2:0];
    endfunction

endpackage

`default_nettype wire

/* design/dst_transition_date_core.sv */
// Channel  | Direction | Beat contents
// s_axis   | in        | year, month, occurrence, weekday, hour, minute, second, millis
// m_axis   | out       | year, month, day, weekday, hour, minute, second, millis
//
// One rule per cycle sustained while m_axis takes every beat.
// The path is four register stages: year shift and divide by 100, leap year and
// weekday sum, mod 7 reduction, day selection into the output register.
// aresetn (synchronous, active low) clears every valid bit; no data is cleared.
// A stall on m_axis is caught by a one-beat skid stage at the output; the stages
// behind it keep filling their bubbles and then hold.
`default_nettype none

module dst_transition_date_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // year, rule_month, rule_occurrence, rule_weekday, rule_hour, rule_minute,
    // rule_second, rule_millis, zero pad
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_year, out_month, out_day, out_weekday, out_hour, out_minute,
    // out_second, out_millis, zero pad
    output logic [55:0]      m_axis_tdata
);

    dstd_pkg::in_beat_t in_beat;
    dstd_pkg::s1_t      s1_data;
    dstd_pkg::s2_t      s2_data;
    dstd_pkg::s3_t      s3_data;
    dstd_pkg::result_t  result;
    logic               s1_valid;
    logic               s1_ready;
    logic               s2_valid;
    logic               s2_ready;
    logic               s3_valid;
    logic               s3_ready;

    assign in_beat = dstd_pkg::in_beat_t'(s_axis_tdata[$bits(dstd_pkg::in_beat_t)-1:0]);
    assign m_axis_tdata = {{dstd_pkg::OUT_PAD_W{1'b0}}, result};

    dstd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_beat   (in_beat),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    dstd_calendar u_calendar (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    dstd_weekday u_weekday (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    dstd_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

endmodule

`default_nettype wire

/* design/dstd_front.sv */
`default_nettype none

// Stage 1: normalize the rule, shift the year, divide by 100
module dstd_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire dstd_pkg::in_beat_t in_beat,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dstd_pkg::s1_t         out_data
);

    logic          valid_reg;
    dstd_pkg::s1_t data_reg;
    dstd_pkg::s1_t data_next;
    logic [15:0]   a;
    logic [28:0]   prod_a;
    logic [27:0]   prod_y;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Year offset by 400, Jan and Feb count with the year before
    assign a = 16'(in_beat.year) + 16'd400
             - ((in_beat.rule_month < dstd_pkg::MONTH_MAR) ? 16'd1 : 16'd0);

    // Divide by 100 through the reciprocal
    assign prod_a = 29'(a) * 29'(dstd_pkg::RECIP_100);
    assign prod_y = 28'(in_beat.year) * 28'(dstd_pkg::RECIP_100);

    always_comb begin
        data_next.rule.year     = in_beat.year;
        data_next.rule.month    = in_beat.rule_month;
        data_next.rule.month_ok = (in_beat.rule_month != 4'd0)
                               && (in_beat.rule_month <= dstd_pkg::MONTH_DEC);
        data_next.rule.last     = (4'(in_beat.rule_occurrence) >= dstd_pkg::OCC_LAST);
        // occurrence zero acts as first
        data_next.rule.nth      = (in_beat.rule_occurrence == 3'd0) ? 2'd0
                                : 2'(in_beat.rule_occurrence - 3'd1);
        // weekday seven acts as Sunday
        data_next.rule.wd       = (in_beat.rule_weekday == dstd_pkg::WD_SPAN) ? 3'd0
                                : in_beat.rule_weekday;
        data_next.rule.hour     = in_beat.rule_hour;
        data_next.rule.minute   = in_beat.rule_minute;
        data_next.rule.second   = in_beat.rule_second;
        data_next.rule.millis   = in_beat.rule_millis;
        data_next.a             = a;
        data_next.qa = prod_a[dstd_pkg::RECIP_SHIFT + 8 : dstd_pkg::RECIP_SHIFT];
        data_next.qy = prod_y[dstd_pkg::RECIP_SHIFT + 8 : dstd_pkg::RECIP_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/dstd_calendar.sv */
`default_nettype none

// Stage 2: leap year, month length, weekday sum of the reference day
module dstd_calendar (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dstd_pkg::s1_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dstd_pkg::s2_t      out_data
);

    logic          valid_reg;
    dstd_pkg::s2_t data_reg;
    dstd_pkg::s2_t data_next;
    logic [15:0]   hundreds;
    logic [15:0]   rem100;
    logic          leap;
    logic [4:0]    dim;
    logic [4:0]    ref_day;
    logic [16:0]   sum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // year mod 100 from the quotient; 100 = 64 + 32 + 4
    assign hundreds = (16'(in_data.qy) << 6) + (16'(in_data.qy) << 5) + (16'(in_data.qy) << 2);
    assign rem100   = 16'(in_data.rule.year) - hundreds;

    // div by 4, and not by 100 unless by 400
    assign leap = (in_data.rule.year[1:0] == 2'b00)
               && ((rem100 != 16'd0) || (in_data.qy[1:0] == 2'b00));

    assign dim     = dstd_pkg::month_days(in_data.rule.month, leap);
    // weekday of the 1st, or of the last day for the last occurrence
    assign ref_day = in_data.rule.last ? dim : 5'd1;

    assign sum = 17'(in_data.a) + 17'(in_data.a[15:2]) - 17'(in_data.qa)
               + 17'(in_data.qa[8:2]) + 17'(dstd_pkg::month_shift(in_data.rule.month))
               + 17'(ref_day);

    always_comb begin
        data_next.rule    = in_data.rule;
        data_next.dim     = dim;
        data_next.ref_sum = sum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/dstd_weekday.sv */
`default_nettype none

// Stage 3: reduce the sum mod 7, distance to the wanted weekday
module dstd_weekday (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dstd_pkg::s2_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dstd_pkg::s3_t      out_data
);

    logic          valid_reg;
    dstd_pkg::s3_t data_reg;
    dstd_pkg::s3_t data_next;
    logic [2:0]    ref_wd;
    logic [3:0]    wd_gap;
    logic [2:0]    off;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign ref_wd = dstd_pkg::mod7_16(in_data.ref_sum);

    // forward from the 1st, backward from the last day
    always_comb begin
        if (in_data.rule.last) begin
            wd_gap = 4'(ref_wd) + 4'(dstd_pkg::WD_SPAN) - 4'(in_data.rule.wd);
        end else begin
            wd_gap = 4'(in_data.rule.wd) + 4'(dstd_pkg::WD_SPAN) - 4'(ref_wd);
        end
        off = (wd_gap >= 4'(dstd_pkg::WD_SPAN)) ? 3'(wd_gap - 4'(dstd_pkg::WD_SPAN))
                                                 : wd_gap[2:0];
    end

    always_comb begin
        data_next.rule = in_data.rule;
        data_next.dim  = in_data.dim;
        data_next.off  = off;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/dstd_select.sv */
`default_nettype none

`include "dst_transition_date_core_defines.svh"

// Stage 4: pick the day, output register with skid stage
module dstd_select (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dstd_pkg::s3_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dstd_pkg::result_t  out_data
);

    logic                out_valid_reg;
    logic                skid_valid_reg;
    dstd_pkg::result_t   out_data_reg;
    dstd_pkg::result_t   skid_data_reg;
    dstd_pkg::result_t   res_next;
    logic [5:0]          nth_day;
    logic [4:0]          day;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // nth: 1 + off + 7*(n-1), back one week past month end
    always_comb begin
        nth_day = 6'd1 + 6'(in_data.off) + ({2'b0, in_data.rule.nth, 2'b0} << 1)
                - 6'(in_data.rule.nth);
        if (in_data.rule.last) begin
            day = in_data.dim - 5'(in_data.off);
        end else if (nth_day > 6'(in_data.dim)) begin
            day = 5'(nth_day - 6'(dstd_pkg::WD_SPAN));
        end else begin
            day = nth_day[4:0];
        end
    end

    always_comb begin
        res_next.out_year    = in_data.rule.year;
        res_next.out_month   = in_data.rule.month;
        res_next.out_day     = in_data.rule.month_ok ? day : 5'd0;
        res_next.out_weekday = in_data.rule.month_ok ? in_data.rule.wd : 3'd0;
        res_next.out_hour    = in_data.rule.hour;
        res_next.out_minute  = in_data.rule.minute;
        res_next.out_second  = in_data.rule.second;
        res_next.out_millis  = in_data.rule.millis;
    end

    // Output and skid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= res_next;
        end
    end

    `DSTD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid holds a beat while the output register is empty")
    `DSTD_ASSERT_NEXT(a_stall_fills_skid,
        in_valid && in_ready && out_valid_reg && !out_ready, skid_valid_reg,
        "beat taken during a stall did not land in the skid stage")
    `DSTD_ASSERT_NOW(a_no_transition,
        out_valid_reg && (out_data_reg.out_month == 4'd0 || out_data_reg.out_month > 4'd12),
        out_data_reg.out_day == 5'd0 && out_data_reg.out_weekday == 3'd0,
        "day or weekday set for a month without transition")
    `DSTD_ASSERT_NOW(a_day_in_month,
        out_valid_reg && out_data_reg.out_month != 4'd0 && out_data_reg.out_month <= 4'd12,
        out_data_reg.out_day >= 5'd1 && out_data_reg.out_weekday <= 3'd6,
        "transition day or weekday out of range")

endmodule

`default_nettype wire

/* bench/tb_dst_transition_date_core.sv */
`timescale 1ns / 1ps

module tb_dst_transition_date_core;
    import dstd_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // year, rule_month, rule_occurrence, rule_weekday, rule_hour, rule_minute,
    // rule_second, rule_millis, zero pad
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // out_year, out_month, out_day, out_weekday, out_hour, out_minute,
    // out_second, out_millis, zero pad
    logic [TDATA_W-1:0]  m_axis_tdata;

    // Holds the transition dates still owed by the core, oldest first
    class transition_scoreboard;
        result_t pending_dates[$];
        int      err_count = 0;

        // Day and weekday on which the rule falls, time fields copied through
        function result_t calc_transition(in_beat_t b);
            int unsigned days_tab[12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            int unsigned shift_tab[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
            int unsigned yr, mon, occ, wd, dim, tgt, a, ref_wd, day, dow;
            result_t r;
            yr  = b.year;
            mon = b.rule_month;
            occ = b.rule_occurrence;
            wd  = b.rule_weekday;
            day = 0;
            dow = 0;
            // weekday 7 folds to Sunday, occurrence 0 to first, 6 and 7 to last
            if (wd == 7) begin
                wd = 0;
            end
            if (occ == 0) begin
                occ = 1;
            end
            // months 0 and 13..15 have no transition
            if (mon >= 1 && mon <= 12) begin
                dim = days_tab[mon-1];
                if (mon == 2 && (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0))) begin
                    dim = 29;
                end
                // weekday of the 1st for nth occurrence, of the last day otherwise
                tgt = (occ < 5) ? 1 : dim;
                a = yr + 400 - ((mon < 3) ? 1 : 0);
                ref_wd = (a + a / 4 - a / 100 + a / 400 + shift_tab[mon-1] + tgt) % 7;
                if (occ < 5) begin
                    day = 1 + (wd + 7 - ref_wd) % 7 + (occ - 1) * 7;
                    if (day > dim) begin
                        day = day - 7;
                    end
                end else begin
                    day = dim - (ref_wd + 7 - wd) % 7;
                end
                dow = wd;
            end
            r.out_year    = b.year;
            r.out_month   = b.rule_month;
            r.out_day     = day[4:0];
            r.out_weekday = dow[2:0];
            r.out_hour    = b.rule_hour;
            r.out_minute  = b.rule_minute;
            r.out_second  = b.rule_second;
            r.out_millis  = b.rule_millis;
            return r;
        endfunction

        function void note_rule(in_beat_t b);
            pending_dates.push_back(calc_transition(b));
        endfunction

        function void field_miss(string name, int unsigned want, int unsigned got);
            err_count++;
            if (err_count <= 10) begin
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
            end
        endfunction

        function void check_date(result_t got);
            result_t want;
            if (pending_dates.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("%0t: result beat with nothing pending, got %h", $realtime, got);
                end
                return;
            end
            want = pending_dates.pop_front();
            if (got.out_year !== want.out_year)
                field_miss("out_year", want.out_year, got.out_year);
            if (got.out_month !== want.out_month)
                field_miss("out_month", want.out_month, got.out_month);
            if (got.out_day !== want.out_day)
                field_miss("out_day", want.out_day, got.out_day);
            if (got.out_weekday !== want.out_weekday)
                field_miss("out_weekday", want.out_weekday, got.out_weekday);
            if (got.out_hour !== want.out_hour)
                field_miss("out_hour", want.out_hour, got.out_hour);
            if (got.out_minute !== want.out_minute)
                field_miss("out_minute", want.out_minute, got.out_minute);
            if (got.out_second !== want.out_second)
                field_miss("out_second", want.out_second, got.out_second);
            if (got.out_millis !== want.out_millis)
                field_miss("out_millis", want.out_millis, got.out_millis);
        endfunction
    endclass

    transition_scoreboard sb = new();

    dst_transition_date_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the core hangs
    initial begin
        #2000000;
        $display("tb_dst_transition_date_core: done, errors");
        $finish;
    end

    // Result side: steps through four stall patterns, beats checked on accept
    int unsigned rx_cycle = 0;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 9) < 3);
            default: m_axis_tready <= ((rx_cycle % 5) < 3);
        endcase
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_date(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
        end
    end

    function automatic in_beat_t mk_rule(int unsigned yr, int unsigned mon, int unsigned occ,
                                         int unsigned wd, int unsigned hh, int unsigned mm,
                                         int unsigned ss, int unsigned ms);
        in_beat_t b;
        b.year            = yr[14:0];
        b.rule_month      = mon[3:0];
        b.rule_occurrence = occ[2:0];
        b.rule_weekday    = wd[2:0];
        b.rule_hour       = hh[4:0];
        b.rule_minute     = mm[5:0];
        b.rule_second     = ss[5:0];
        b.rule_millis     = ms[9:0];
        return b;
    endfunction

    // Mostly legal rules, with a share of out-of-range codes and full-width values
    function automatic in_beat_t rand_rule();
        int unsigned yr, mon, occ, wd, hh, mm, ss, ms;
        yr  = ($urandom_range(0, 9) < 7) ? $urandom_range(1601, 30827) : $urandom_range(0, 32767);
        mon = ($urandom_range(0, 19) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 15);
        occ = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 5) : $urandom_range(0, 7);
        wd  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 7);
        hh  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 31);
        mm  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 63);
        ss  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 63);
        ms  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 999) : $urandom_range(0, 1023);
        return mk_rule(yr, mon, occ, wd, hh, mm, ss, ms);
    endfunction

    // Present one rule beat and hold it until the core takes it
    task automatic push_rule(in_beat_t b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(b);
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_rule(b);
    endtask

    task automatic idle_cycles(int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Hold the sender off until every owed result has come back or max_cycles have passed
    task automatic wait_drained(int unsigned max_cycles);
        int unsigned n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_dates.size() != 0 && n < max_cycles) begin
            @(posedge aclk);
            n++;
        end
    endtask

    initial begin
        int unsigned burst;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every month code, occurrence and weekday code
        push_rule(mk_rule(1601, 1, 1, 0, 0, 0, 0, 0));
        push_rule(mk_rule(30827, 12, 5, 6, 23, 59, 59, 999));
        push_rule(mk_rule(0, 3, 2, 3, 31, 63, 63, 1023));
        push_rule(mk_rule(32767, 10, 5, 0, 12, 30, 0, 500));
        push_rule(mk_rule(2024, 2, 5, 4, 2, 0, 0, 0));
        push_rule(mk_rule(2023, 2, 4, 2, 3, 0, 0, 0));
        push_rule(mk_rule(1900, 2, 5, 3, 1, 1, 1, 1));
        push_rule(mk_rule(2000, 2, 5, 1, 4, 5, 6, 7));
        push_rule(mk_rule(2021, 3, 2, 0, 2, 0, 0, 0));
        push_rule(mk_rule(2021, 11, 1, 0, 2, 0, 0, 0));
        // no transition: month zero and months past December
        push_rule(mk_rule(2021, 0, 2, 0, 2, 0, 0, 0));
        push_rule(mk_rule(2021, 13, 3, 4, 5, 6, 7, 8));
        push_rule(mk_rule(2021, 14, 5, 6, 22, 58, 58, 998));
        push_rule(mk_rule(2021, 15, 7, 7, 31, 63, 63, 1023));
        // occurrence zero, occurrence above five, weekday seven
        push_rule(mk_rule(2022, 4, 0, 5, 9, 15, 30, 250));
        push_rule(mk_rule(2022, 9, 6, 2, 10, 0, 0, 0));
        push_rule(mk_rule(2022, 6, 7, 1, 11, 0, 0, 0));
        push_rule(mk_rule(2022, 10, 5, 7, 3, 0, 0, 0));
        // remaining months and late nth occurrences near the month end
        push_rule(mk_rule(2019, 5, 3, 3, 1, 0, 0, 0));
        push_rule(mk_rule(2019, 7, 4, 6, 1, 0, 0, 0));
        push_rule(mk_rule(2019, 8, 1, 4, 1, 0, 0, 0));
        push_rule(mk_rule(2020, 1, 4, 6, 0, 0, 0, 0));
        push_rule(mk_rule(2020, 12, 1, 1, 0, 0, 0, 0));
        push_rule(mk_rule(2015, 2, 4, 0, 0, 0, 0, 0));
        wait_drained(100000);

        // Random rules in bursts with gaps; one full drain midway
        burst = 0;
        for (int i = 0; i < 1100; i++) begin
            if (i == 550) begin
                wait_drained(100000);
            end
            if (burst == 0) begin
                idle_cycles($urandom_range(1, 8));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            end
            push_rule(rand_rule());
            burst--;
        end

        wait_drained(100000);
        repeat (16) @(posedge aclk);
        if (sb.err_count == 0 && sb.pending_dates.size() == 0) begin
            $display("tb_dst_transition_date_core: done, clean");
        end else begin
            $display("tb_dst_transition_date_core: done, errors");
        end
        $finish;
    end

endmodule
